// ----- design/vit_pkg.sv -----
// ----------------------------------------------------------------------------
// vit_pkg
// Shared types and constants of the value interning table: command codes,
// sequencer states, per-cell compare flags and default sizes.
// ----------------------------------------------------------------------------
package vit_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed widths of the port fields
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned PORT_ID_W   = 10;
  localparam int unsigned PORT_VAL_W  = 32;

  // cells per first-level group of the match tree
  localparam int unsigned GROUP_SIZE = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 2'd0,
    CMD_FIND_ID    = 2'd1,
    CMD_FIND_VALUE = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_EXEC
  } state_e;

  // compare flags of one cell against the query
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

// ----- design/vit_ram.sv -----
// ----------------------------------------------------------------------------
// vit_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vit_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/vit_cell.sv -----
// ----------------------------------------------------------------------------
// vit_cell
// One slot of the sorted entry chain. Compares its entry against the query
// and, on an insert, either keeps its entry, takes the new entry, or takes
// the entry of its left neighbor so that the chain shifts right.
// ----------------------------------------------------------------------------
module vit_cell
  import vit_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned ID_W       = 10,
  parameter int unsigned CNT_W      = 11
) (
  input  logic                         clk_i,
  input  logic                         shift_en_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic signed [VALUE_BITS-1:0] q_value_i,
  input  logic [ID_W-1:0]              q_id_i,
  input  logic signed [VALUE_BITS-1:0] left_value_i,
  input  logic [ID_W-1:0]              left_id_i,
  input  logic                         left_lt_i,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic [ID_W-1:0]              id_o,
  output cell_flags_t                  flags_o
);

  logic signed [VALUE_BITS-1:0] value_q;
  logic [ID_W-1:0]              id_q;
  logic                         live;

  // a slot holds an entry when it lies below the fill count
  assign live       = count_i > CNT_W'(IDX);
  assign flags_o.lt = live && (value_q < q_value_i);
  assign flags_o.eq = live && (value_q == q_value_i);

  // insert: first slot not below the query takes it, later slots shift right
  always_ff @(posedge clk_i) begin
    if (shift_en_i && !flags_o.lt) begin
      if (left_lt_i) begin
        value_q <= q_value_i;
        id_q    <= q_id_i;
      end else begin
        value_q <= left_value_i;
        id_q    <= left_id_i;
      end
    end
  end

  assign value_o = value_q;
  assign id_o    = id_q;

endmodule

// ----- design/value_interning_table.sv -----
// ----------------------------------------------------------------------------
// value_interning_table
// Interns signed values into dense ids given out in order of first arrival.
// Path: an input passes the query load, the group match stage and the final
//   match stage, then the result register, which waits while the output stalls.
// Ordering: the input stalls until the sequencer is idle; it runs one item at a time
//   through the two registered levels of the match tree over the cell chain.
// Reset: the fill count clears at once and no result is pending; entry
//   storage is not cleared, there is no clearing pass.
// ----------------------------------------------------------------------------
module value_interning_table
  import vit_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [CMD_W-1:0]             cmd_i,
  input  logic signed [PORT_VAL_W-1:0] value_i,
  input  logic [PORT_ID_W-1:0]         id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [PORT_ID_W-1:0]         id_out_o,
  output logic signed [PORT_VAL_W-1:0] value_out_o,
  output logic                         status_o
);

  localparam int unsigned ID_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > PORT_ID_W) ? CNT_W : PORT_ID_W;
  localparam int unsigned NGRP  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  state_e state_q, state_d;

  // query registers
  logic [CMD_W-1:0]             q_cmd_q;
  logic signed [VALUE_BITS-1:0] q_value_q;
  logic [PORT_ID_W-1:0]         q_id_q;
  logic [CNT_W-1:0]             entry_count_q, entry_count_d;

  // cell chain
  logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [ID_W-1:0]              cell_id    [CAPACITY];
  cell_flags_t                  cell_flags [CAPACITY];
  logic                         shift_en;
  logic [ID_W-1:0]              new_id;

  // match tree
  logic            grp_hit_d [NGRP];
  logic [ID_W-1:0] grp_id_d  [NGRP];
  logic            grp_hit_q [NGRP];
  logic [ID_W-1:0] grp_id_q  [NGRP];
  logic            fin_hit_d, fin_hit_q;
  logic [ID_W-1:0] fin_id_d, fin_id_q;

  // id store
  logic signed [VALUE_BITS-1:0] rd_value;

  // result register
  logic                         out_valid_q;
  logic                         found_q, status_q;
  logic [ID_W-1:0]              res_id_q;
  logic signed [VALUE_BITS-1:0] res_value_q;
  logic                         found_d, status_d;
  logic [ID_W-1:0]              res_id_d;
  logic signed [VALUE_BITS-1:0] res_value_d;
  logic                         go;
  logic                         in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign new_id     = ID_W'(entry_count_q);

  // query capture on an input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      q_cmd_q   <= cmd_i;
      q_value_q <= VALUE_BITS'(value_i);
      q_id_q    <= id_i;
    end
  end

  // sorted chain of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      vit_cell #(
        .IDX       (i),
        .VALUE_BITS(VALUE_BITS),
        .ID_W      (ID_W),
        .CNT_W     (CNT_W)
      ) u_cell (
        .clk_i       (clk_i),
        .shift_en_i  (shift_en),
        .count_i     (entry_count_q),
        .q_value_i   (q_value_q),
        .q_id_i      (new_id),
        .left_value_i(q_value_q),
        .left_id_i   (new_id),
        .left_lt_i   (1'b1),
        .value_o     (cell_value[i]),
        .id_o        (cell_id[i]),
        .flags_o     (cell_flags[i])
      );
    end else begin : g_body
      vit_cell #(
        .IDX       (i),
        .VALUE_BITS(VALUE_BITS),
        .ID_W      (ID_W),
        .CNT_W     (CNT_W)
      ) u_cell (
        .clk_i       (clk_i),
        .shift_en_i  (shift_en),
        .count_i     (entry_count_q),
        .q_value_i   (q_value_q),
        .q_id_i      (new_id),
        .left_value_i(cell_value[i-1]),
        .left_id_i   (cell_id[i-1]),
        .left_lt_i   (cell_flags[i-1].lt),
        .value_o     (cell_value[i]),
        .id_o        (cell_id[i]),
        .flags_o     (cell_flags[i])
      );
    end
  end

  // first tree level: match and id per group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_id_d[g]  = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          grp_hit_d[g] = grp_hit_d[g] | cell_flags[g*GROUP_SIZE+k].eq;
          grp_id_d[g]  = grp_id_d[g] |
                         (cell_flags[g*GROUP_SIZE+k].eq ? cell_id[g*GROUP_SIZE+k] : '0);
        end
      end
    end
  end

  // second tree level: at most one cell matches, so an or-merge suffices
  always_comb begin
    fin_hit_d = 1'b0;
    fin_id_d  = '0;
    for (int g = 0; g < NGRP; g++) begin
      fin_hit_d = fin_hit_d | grp_hit_q[g];
      fin_id_d  = fin_id_d | (grp_hit_q[g] ? grp_id_q[g] : '0);
    end
  end

  // match tree registers
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_q[g] <= grp_hit_d[g];
      grp_id_q[g]  <= grp_id_d[g];
    end
    fin_hit_q <= fin_hit_d;
    fin_id_q  <= fin_id_d;
  end

  // id to value store
  vit_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (shift_en),
    .waddr_i(new_id),
    .wdata_i(q_value_q),
    .raddr_i(ID_W'(q_id_q)),
    .rdata_o(rd_value)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
    end
  end

  // next state, command decode and result
  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    shift_en      = 1'b0;
    found_d       = 1'b0;
    status_d      = 1'b0;
    res_id_d      = '0;
    res_value_d   = '0;
    go            = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_RED;
      end
      ST_RED: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!(out_valid_q && out_stall_i)) begin
          go      = 1'b1;
          state_d = ST_IDLE;
          unique case (cmd_e'(q_cmd_q))
            CMD_ADD: begin
              if (fin_hit_q) begin
                found_d     = 1'b1;
                res_id_d    = fin_id_q;
                res_value_d = q_value_q;
              end else if (entry_count_q >= CNT_W'(CAPACITY)) begin
                status_d = 1'b1;
              end else begin
                res_id_d      = new_id;
                res_value_d   = q_value_q;
                shift_en      = 1'b1;
                entry_count_d = entry_count_q + 1'b1;
              end
            end
            CMD_FIND_ID: begin
              if (CMP_W'(q_id_q) < CMP_W'(entry_count_q)) begin
                found_d     = 1'b1;
                res_id_d    = ID_W'(q_id_q);
                res_value_d = rd_value;
              end
            end
            CMD_FIND_VALUE: begin
              if (fin_hit_q) begin
                found_d     = 1'b1;
                res_id_d    = fin_id_q;
                res_value_d = q_value_q;
              end
            end
            CMD_CLEAR: begin
              entry_count_d = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (go) begin
      found_q     <= found_d;
      status_q    <= status_d;
      res_id_q    <= res_id_d;
      res_value_q <= res_value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign status_o    = status_q;
  assign id_out_o    = PORT_ID_W'(res_id_q);
  assign value_out_o = PORT_VAL_W'(res_value_q);

`ifndef SYNTH
  // fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // an input transfer starts the compare pass
  a_xfer_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_CMP))
    else $error("input transfer did not start compare");

  // a new result only comes out of the execute state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result raised outside execute");

  // fill count steps by one or drops to zero
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_count_q != $past(entry_count_q)) |->
      (entry_count_q == $past(entry_count_q) + 1'b1 || entry_count_q == '0))
    else $error("entry count jumped");
`endif

endmodule
